// ===== hdl/rau_pkg.sv =====
`timescale 1ns / 1ps

package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam int SAT_WIDTH = 34;
  localparam logic [SAT_WIDTH-1:0] NUM_MAX_POS = 34'h0_7FFF_FFFF;
  localparam logic [SAT_WIDTH-1:0] NUM_MAX_NEG = 34'h0_8000_0000;
  localparam logic [SAT_WIDTH-1:0] DEN_MAX     = 34'h0_3FFF_FFFF;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

// ===== hdl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// channel | signals                                  | direction
// input   | in_valid, in_stall, opcode, a/b num/den  | item in
// output  | out_valid, out_stall, res_num, res_den,  | item out
//         | div_error                                |
// One item at a time; in_stall is high from acceptance until the result is
// loaded into the output register. Add/sub: gcd plus two divisions plus the
// final gcd and two divisions; mul/div: final gcd and two divisions. A zero
// numerator skips the final gcd and divisions; errors go straight to the
// output register. Reset is synchronous; out_stall holds the result and
// blocks the next result.

module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              res_num,
  output logic [29:0]                     res_den,
  output logic                            div_error
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int CW = (PW > SAT_WIDTH) ? PW : SAT_WIDTH;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_G1S  = 5'd1;
  localparam logic [4:0] S_G1W  = 5'd2;
  localparam logic [4:0] S_D1S  = 5'd3;
  localparam logic [4:0] S_D1W  = 5'd4;
  localparam logic [4:0] S_D2S  = 5'd5;
  localparam logic [4:0] S_D2W  = 5'd6;
  localparam logic [4:0] S_MA   = 5'd7;
  localparam logic [4:0] S_MB   = 5'd8;
  localparam logic [4:0] S_MC   = 5'd9;
  localparam logic [4:0] S_COMB = 5'd10;
  localparam logic [4:0] S_M1   = 5'd11;
  localparam logic [4:0] S_M2   = 5'd12;
  localparam logic [4:0] S_CHK  = 5'd13;
  localparam logic [4:0] S_G2S  = 5'd14;
  localparam logic [4:0] S_G2W  = 5'd15;
  localparam logic [4:0] S_D3S  = 5'd16;
  localparam logic [4:0] S_D3W  = 5'd17;
  localparam logic [4:0] S_D4S  = 5'd18;
  localparam logic [4:0] S_D4W  = 5'd19;
  localparam logic [4:0] S_SAT  = 5'd20;
  localparam logic [4:0] S_OUT  = 5'd21;

  logic [4:0]    state;
  logic [W-1:0]  na, da, nb, db;
  logic          sa, sb, rs;
  logic [W-1:0]  qa, qb;
  logic [PW-1:0] g, rn, rd, ta, tb;
  logic [31:0]   rnum;
  logic [29:0]   rden;
  logic          rerr;

  logic [W-1:0]  m_na, m_da, m_nb, m_db;
  logic          s_na, s_da, s_nb, s_db;
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [PW-1:0] gcd_x, gcd_y, gcd_g, div_n, div_d, div_q;
  unit_ctl_t     gcd_ctl, div_ctl;
  logic [CW-1:0] rn_ext, rd_ext, rn_sat, rd_sat;
  logic          in_acc;

  assign s_na = a_num[W-1];
  assign s_da = a_den[W-1];
  assign s_nb = b_num[W-1];
  assign s_db = b_den[W-1];
  assign m_na = s_na ? W'(0) - a_num : a_num;
  assign m_da = s_da ? W'(0) - a_den : a_den;
  assign m_nb = s_nb ? W'(0) - b_num : b_num;
  assign m_db = s_db ? W'(0) - b_den : b_den;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    mul_a = na;
    mul_b = nb;
    unique case (state)
      S_MA:    begin mul_a = qa; mul_b = db; end
      S_MB:    begin mul_a = na; mul_b = qb; end
      S_MC:    begin mul_a = nb; mul_b = qa; end
      S_M2:    begin mul_a = da; mul_b = db; end
      default: begin mul_a = na; mul_b = nb; end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  assign gcd_ctl.start = (state == S_G1S) || (state == S_G2S);
  assign gcd_x = (state == S_G1S) ? PW'(da) : rn;
  assign gcd_y = (state == S_G1S) ? PW'(db) : rd;

  assign div_ctl.start = (state == S_D1S) || (state == S_D2S) ||
                         (state == S_D3S) || (state == S_D4S);
  always_comb begin
    div_n = rd;
    unique case (state)
      S_D1S:   div_n = PW'(da);
      S_D2S:   div_n = PW'(db);
      S_D3S:   div_n = rn;
      default: div_n = rd;
    endcase
  end
  assign div_d = g;

  rau_gcd #(.WIDTH(PW)) u_gcd (
    .clk  (clk),
    .rst  (rst),
    .start(gcd_ctl.start),
    .x_in (gcd_x),
    .y_in (gcd_y),
    .done (gcd_ctl.done),
    .g    (gcd_g)
  );

  rau_div #(.WIDTH(PW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_ctl.start),
    .n_in (div_n),
    .d_in (div_d),
    .done (div_ctl.done),
    .quo  (div_q)
  );

  assign rn_ext = CW'(rn);
  assign rd_ext = CW'(rd);
  always_comb begin
    if (rs) begin
      rn_sat = (rn_ext > CW'(NUM_MAX_NEG)) ? CW'(NUM_MAX_NEG) : rn_ext;
    end else begin
      rn_sat = (rn_ext > CW'(NUM_MAX_POS)) ? CW'(NUM_MAX_POS) : rn_ext;
    end
    rd_sat = (rd_ext > CW'(DEN_MAX)) ? CW'(DEN_MAX) : rd_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            na <= m_na;
            da <= m_da;
            sa <= s_na != s_da;
            if (opcode == OP_DIV) begin
              nb <= m_db;
              db <= m_nb;
            end else begin
              nb <= m_nb;
              db <= m_db;
            end
            sb <= (s_nb != s_db) ^ (opcode == OP_SUB);
            if (m_da == '0 || m_db == '0 || (opcode == OP_DIV && m_nb == '0)) begin
              rnum  <= '0;
              rden  <= '0;
              rerr  <= 1'b1;
              state <= S_OUT;
            end else if (opcode == OP_ADD || opcode == OP_SUB) begin
              state <= S_G1S;
            end else begin
              state <= S_M1;
            end
          end
        end
        S_G1S: state <= S_G1W;
        S_G1W: begin
          if (gcd_ctl.done) begin
            g     <= gcd_g;
            state <= S_D1S;
          end
        end
        S_D1S: state <= S_D1W;
        S_D1W: begin
          if (div_ctl.done) begin
            qa    <= div_q[W-1:0];
            state <= S_D2S;
          end
        end
        S_D2S: state <= S_D2W;
        S_D2W: begin
          if (div_ctl.done) begin
            qb    <= div_q[W-1:0];
            state <= S_MA;
          end
        end
        S_MA: begin
          rd    <= prod;
          state <= S_MB;
        end
        S_MB: begin
          ta    <= prod;
          state <= S_MC;
        end
        S_MC: begin
          tb    <= prod;
          state <= S_COMB;
        end
        S_COMB: begin
          if (sa == sb) begin
            rn <= ta + tb;
            rs <= sa;
          end else if (ta >= tb) begin
            rn <= ta - tb;
            rs <= sa;
          end else begin
            rn <= tb - ta;
            rs <= sb;
          end
          state <= S_CHK;
        end
        S_M1: begin
          rn    <= prod;
          rs    <= sa != sb;
          state <= S_M2;
        end
        S_M2: begin
          rd    <= prod;
          state <= S_CHK;
        end
        S_CHK: begin
          if (rn == '0) begin
            rnum  <= '0;
            rden  <= 30'd1;
            rerr  <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_G2S;
          end
        end
        S_G2S: state <= S_G2W;
        S_G2W: begin
          if (gcd_ctl.done) begin
            g     <= gcd_g;
            state <= S_D3S;
          end
        end
        S_D3S: state <= S_D3W;
        S_D3W: begin
          if (div_ctl.done) begin
            rn    <= div_q;
            state <= S_D4S;
          end
        end
        S_D4S: state <= S_D4W;
        S_D4W: begin
          if (div_ctl.done) begin
            rd    <= div_q;
            state <= S_SAT;
          end
        end
        S_SAT: begin
          rnum  <= rs ? 32'(CW'(0) - rn_sat) : rn_sat[31:0];
          rden  <= rd_sat[29:0];
          rerr  <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            res_num   <= rnum;
            res_den   <= rden;
            div_error <= rerr;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/rau_gcd.sv =====
`timescale 1ns / 1ps

module rau_gcd
  import rau_pkg::*;
#(
  parameter int WIDTH = 2 * OPERAND_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x_in,
  input  logic [WIDTH-1:0] y_in,
  output logic             done,
  output logic [WIDTH-1:0] g
);

  localparam int KW = $clog2(WIDTH + 1);
  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_TWO  = 2'd1;
  localparam logic [1:0] G_RUN  = 2'd2;

  logic [1:0]       state;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [KW-1:0]    k;

  // binary gcd, both operands nonzero
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        G_IDLE: begin
          if (start) begin
            x     <= x_in;
            y     <= y_in;
            k     <= '0;
            state <= G_TWO;
          end
        end
        G_TWO: begin
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else begin
            state <= G_RUN;
          end
        end
        G_RUN: begin
          if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x == y) begin
            g     <= x << k;
            done  <= 1'b1;
            state <= G_IDLE;
          end else if (x > y) begin
            x <= x - y;
          end else begin
            y <= y - x;
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/rau_div.sv =====
`timescale 1ns / 1ps

module rau_div
  import rau_pkg::*;
#(
  parameter int WIDTH = 2 * OPERAND_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] n_in,
  input  logic [WIDTH-1:0] d_in,
  output logic             done,
  output logic [WIDTH-1:0] quo
);

  localparam int CNTW = $clog2(WIDTH + 1);

  logic             busy;
  logic [CNTW-1:0]  cnt;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] d;
  logic [WIDTH:0]   trial;

  assign trial = {rem, quo[WIDTH-1]};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          quo  <= n_in;
          d    <= d_in;
          rem  <= '0;
          cnt  <= CNTW'(WIDTH);
          busy <= 1'b1;
        end
      end else begin
        if (trial >= {1'b0, d}) begin
          rem <= WIDTH'(trial - {1'b0, d});
          quo <= {quo[WIDTH-2:0], 1'b1};
        end else begin
          rem <= trial[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== tb/rational_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_RANDOM = 1130;

  typedef struct {
    logic [1:0] opcode;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;
  } frac_op_t;

  typedef struct {
    logic signed [31:0] num;
    logic [29:0] den;
    logic err;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = OP_ADD;
  logic signed [W-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] res_num;
  logic [29:0] res_den;
  logic div_error;

  frac_op_t pending_ops[$];
  frac_res_t expected_fracs[$];
  int fail_count = 0;
  int sent_count = 0;
  int got_count = 0;
  int err_count = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_count = 0;
  bit hold_done = 1'b0;
  bit stim_done = 1'b0;

  rational_arithmetic_unit #(.OPERAND_WIDTH(W)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_stall(out_stall), .res_num(res_num),
    .res_den(res_den), .div_error(div_error)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] mag_of(logic signed [W-1:0] v);
    logic signed [63:0] x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (x != 0) begin
      t = y % x;
      y = x;
      x = t;
    end
    return y;
  endfunction

  function automatic frac_res_t reduce_frac(frac_op_t op);
    frac_res_t r;
    logic [63:0] na, da, nb, db, rn, rd, g, ta, tb, t;
    bit sa, sb, rs;
    na = mag_of(op.a_num);
    da = mag_of(op.a_den);
    nb = mag_of(op.b_num);
    db = mag_of(op.b_den);
    sa = (op.a_num < 0) != (op.a_den < 0);
    sb = (op.b_num < 0) != (op.b_den < 0);
    r.num = '0;
    r.den = '0;
    r.err = 1'b1;
    if (da == 0 || db == 0 || (op.opcode == OP_DIV && nb == 0)) return r;
    r.err = 1'b0;
    if (op.opcode == OP_ADD || op.opcode == OP_SUB) begin
      if (op.opcode == OP_SUB) sb = !sb;
      g = gcd_of(da, db);
      rd = (da / g) * db;
      ta = na * (rd / da);
      tb = nb * (rd / db);
      if (sa == sb) begin
        rn = ta + tb;
        rs = sa;
      end else if (ta >= tb) begin
        rn = ta - tb;
        rs = sa;
      end else begin
        rn = tb - ta;
        rs = sb;
      end
    end else begin
      if (op.opcode == OP_DIV) begin
        t = nb;
        nb = db;
        db = t;
      end
      rn = na * nb;
      rd = da * db;
      rs = sa != sb;
    end
    if (rn == 0) begin
      r.den = 30'd1;
      return r;
    end
    g = gcd_of(rn, rd);
    rn = rn / g;
    rd = rd / g;
    if (rs) begin
      if (rn > 64'h8000_0000) rn = 64'h8000_0000;
      r.num = -rn[31:0];
    end else begin
      if (rn > 64'h7FFF_FFFF) rn = 64'h7FFF_FFFF;
      r.num = rn[31:0];
    end
    if (rd > 64'h3FFF_FFFF) rd = 64'h3FFF_FFFF;
    r.den = rd[29:0];
    return r;
  endfunction

  function automatic logic signed [W-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8001;
      1: return 16'sh8000;
      2: return '0;
      3, 4: return $signed(16'($urandom_range(0, 24))) - 16'sd12;
      5, 6: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  function automatic frac_op_t make_op(logic [1:0] o, int an, int ad, int bn, int bd);
    frac_op_t op;
    op.opcode = o;
    op.a_num = W'(an);
    op.a_den = W'(ad);
    op.b_num = W'(bn);
    op.b_den = W'(bd);
    return op;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 300);
  endfunction

  initial begin
    frac_op_t op;
    pending_ops.push_back(make_op(OP_ADD, 1, 2, 1, 3));
    pending_ops.push_back(make_op(OP_SUB, 1, 2, 1, 2));
    pending_ops.push_back(make_op(OP_MUL, -3, 4, 2, -9));
    pending_ops.push_back(make_op(OP_DIV, 5, 7, -10, 21));
    pending_ops.push_back(make_op(OP_ADD, 1, 0, 1, 1));
    pending_ops.push_back(make_op(OP_SUB, 1, 1, 1, 0));
    pending_ops.push_back(make_op(OP_DIV, 3, 4, 0, 5));
    pending_ops.push_back(make_op(OP_MUL, 0, 5, 7, 3));
    pending_ops.push_back(make_op(OP_MUL, 32767, 1, 32767, 1));
    pending_ops.push_back(make_op(OP_MUL, -32768, 1, -32768, 1));
    pending_ops.push_back(make_op(OP_MUL, -32768, 1, 32767, 1));
    pending_ops.push_back(make_op(OP_DIV, 1, 32767, 1, -32768));
    pending_ops.push_back(make_op(OP_ADD, -32768, 32767, -32768, 32765));
    pending_ops.push_back(make_op(OP_SUB, 32767, -32768, -32767, 32767));
    pending_ops.push_back(make_op(OP_ADD, -1, -1, -1, -1));
    pending_ops.push_back(make_op(OP_SUB, 32767, 32766, 32765, 32764));
    pending_ops.push_back(make_op(OP_DIV, -32768, -32768, -32768, -32768));
    pending_ops.push_back(make_op(OP_MUL, 32767, -32767, 0, 0));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      op.opcode = 2'($urandom_range(0, 3));
      op.a_num = rand_operand();
      op.a_den = rand_operand();
      op.b_num = rand_operand();
      op.b_den = rand_operand();
      pending_ops.push_back(op);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  logic in_acc;
  always @(posedge clk) begin
    in_acc <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      frac_op_t op;
      op.opcode = opcode;
      op.a_num = a_num;
      op.a_den = a_den;
      op.b_num = b_num;
      op.b_den = b_den;
      expected_fracs.push_back(reduce_frac(op));
      sent_count <= sent_count + 1;
    end
  end

  // Driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_acc) begin
        in_valid <= 1'b0;
        send_gap <= pick_gap();
      end else if (!in_valid) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (pending_ops.size() > 0) begin
          frac_op_t op;
          op = pending_ops.pop_front();
          opcode <= op.opcode;
          a_num <= op.a_num;
          a_den <= op.a_den;
          b_num <= op.b_num;
          b_den <= op.b_den;
          in_valid <= 1'b1;
        end else stim_done <= 1'b1;
      end
    end
  end

  // Receiver stall control; one long hold-off once traffic is going
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && sent_count == 300) begin
        out_stall <= 1'b1;
        hold_count <= hold_count + 1;
        if (hold_count == 2000) hold_done <= 1'b1;
      end else if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if (out_stall) begin
        out_stall <= 1'b0;
      end else begin
        recv_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      frac_res_t e;
      got_count <= got_count + 1;
      if (expected_fracs.size() == 0) begin
        $error("result with nothing expected: res_num=%0d res_den=%0d", res_num, res_den);
        fail_count <= fail_count + 1;
      end else begin
        e = expected_fracs.pop_front();
        if (e.err) err_count <= err_count + 1;
        if (res_num !== e.num) begin
          $error("res_num: expected %0d, got %0d", e.num, res_num);
          fail_count <= fail_count + 1;
        end
        if (res_den !== e.den) begin
          $error("res_den: expected %0d, got %0d", e.den, res_den);
          fail_count <= fail_count + 1;
        end
        if (div_error !== e.err) begin
          $error("div_error: expected %0d, got %0d", e.err, div_error);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d items sent, %0d results seen", sent_count, got_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    wait (stim_done && expected_fracs.size() == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d items over all four operations, %0d of them error cases,",
      sent_count, err_count);
    $display("with random gaps on both sides and one long output hold-off");
    if (fail_count == 0 && expected_fracs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
